[hdl/text_frame_byte_parser_macros.svh]
// Assertion macros for the text frame byte parser checker
`ifndef TEXT_FRAME_BYTE_PARSER_MACROS_SVH
`define TEXT_FRAME_BYTE_PARSER_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define TFBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define TFBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hdl/tfbp_pkg.sv]
// ----------------------------------------------------------------------------
// tfbp_pkg
// Shared types and constants of the text frame byte parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tfbp_pkg;
  localparam int unsigned LengthBitsDefault = 64;
  localparam int unsigned LimitW = 13;
  localparam int unsigned CountW = 13;
  localparam int unsigned ClLen = 14;

  typedef enum logic [3:0] {
    PH_START, PH_START_LF, PH_CMD, PH_CMD_LF, PH_HDR, PH_HDR_LF, PH_KEY,
    PH_VAL, PH_VAL_LF, PH_BODY_NUL, PH_BODY_LEN, PH_BODY_FINAL
  } phase_e;

  typedef enum logic [1:0] {ST_MORE = 2'd0, ST_DONE = 2'd1, ST_FAIL = 2'd2} status_e;
  typedef enum logic [1:0] {ERR_BAD = 2'd0, ERR_CMD_LONG = 2'd1, ERR_HDR_LARGE = 2'd2}
    err_e;
  typedef enum logic [2:0] {
    CL_NONE, CL_CMD, CL_CMD_END, CL_KEY, CL_KEY_END, CL_VAL, CL_VAL_END, CL_BODY
  } class_e;

  localparam logic [1:0] CFG_CMD = 2'd0;
  localparam logic [1:0] CFG_KEY = 2'd1;
  localparam logic [1:0] CFG_VAL = 2'd2;

  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // byte classification passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       is_lf;
    logic       is_cr;
    logic       is_colon;
    logic       is_nul;
    logic       is_print;
    logic       is_digit;
    logic [3:0] digit;
  } tok_t;

  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0: c = "c";  4'd1: c = "o";  4'd2: c = "n";  4'd3: c = "t";
      4'd4: c = "e";  4'd5: c = "n";  4'd6: c = "t";  4'd7: c = "-";
      4'd8: c = "l";  4'd9: c = "e";  4'd10: c = "n"; 4'd11: c = "g";
      4'd12: c = "t"; 4'd13: c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction
endpackage

[hdl/tfbp_front.sv]
// ----------------------------------------------------------------------------
// tfbp_front
// Accepts input bytes, classifies them, and queues them for the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tfbp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte_i,
  output logic            tok_valid_o,
  input  logic            tok_ready_i,
  output tfbp_pkg::tok_t  tok_o
);
  tfbp_pkg::tok_t       mem_q [2];
  logic           [1:0] cnt_q, cnt_d;
  logic                 wp_q, rp_q;
  tfbp_pkg::tok_t       t;
  logic                 push, pop;

  always_comb begin
    t.data     = in_byte_i;
    t.is_lf    = in_byte_i == tfbp_pkg::CH_LF;
    t.is_cr    = in_byte_i == tfbp_pkg::CH_CR;
    t.is_colon = in_byte_i == tfbp_pkg::CH_COLON;
    t.is_nul   = in_byte_i == 8'h00;
    t.is_print = in_byte_i >= 8'h20 && in_byte_i <= 8'h7E;
    t.is_digit = in_byte_i >= 8'h30 && in_byte_i <= 8'h39;
    t.digit    = 4'(in_byte_i - 8'h30);
  end

  assign in_ready    = cnt_q != 2'd2;
  assign push        = in_valid && in_ready;
  assign tok_valid_o = cnt_q != 2'd0;
  assign pop         = tok_valid_o && tok_ready_i;
  assign tok_o       = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= t;
  end
endmodule

[hdl/tfbp_back.sv]
// ----------------------------------------------------------------------------
// tfbp_back
// Frame parse state machine with registered result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tfbp_back #(
  parameter int unsigned LENGTH_BITS = tfbp_pkg::LengthBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tok_valid_i,
  output logic                 tok_ready_o,
  input  tfbp_pkg::tok_t       tok_i,
  input  logic [12:0]          cmd_lim_i,
  input  logic [12:0]          key_lim_i,
  input  logic [12:0]          val_lim_i,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status_o,
  output logic [1:0]           error_kind_o,
  output logic [2:0]           byte_class_o,
  output logic [7:0]           out_byte_o
);
  localparam int unsigned LW = LENGTH_BITS;

  tfbp_pkg::phase_e phase_q, phase_d;
  logic [12:0]   cnt_q, cnt_d;
  logic [3:0]    kpos_q, kpos_d;
  logic          kmatch_q, kmatch_d, isl_q, isl_d, dv_q, dv_d;
  logic          lp_q, lp_d, lbad_q, lbad_d;
  logic [LW-1:0] acc_q, acc_d, dlen_q, dlen_d, rem_q, rem_d;
  tfbp_pkg::err_e fk_q, fk_d;

  logic          ov_q;
  logic [1:0]    st_q, ek_q;
  logic [2:0]    cl_q;
  logic [7:0]    ob_q;
  logic          step;

  logic [1:0]    st;
  logic [2:0]    cl;
  logic [7:0]    ob;
  logic          fail, done;
  logic [LW+3:0] prod;
  logic [7:0]    c;

  assign tok_ready_o = !ov_q || out_ready;
  assign step        = tok_valid_i && tok_ready_o;
  assign c           = tok_i.data;
  // acc*10 + d, overflow when any bit from LW upward is set
  assign prod        = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + (LW + 4)'(tok_i.digit);

  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; kpos_d = kpos_q; kmatch_d = kmatch_q;
    isl_d = isl_q; dv_d = dv_q; lp_d = lp_q; lbad_d = lbad_q;
    acc_d = acc_q; dlen_d = dlen_q; rem_d = rem_q; fk_d = fk_q;
    fail = 1'b0; done = 1'b0; cl = tfbp_pkg::CL_NONE; ob = 8'h00;
    unique case (phase_q)
      tfbp_pkg::PH_START: begin
        if (tok_i.is_lf) done = 1'b1;
        else if (tok_i.is_cr) phase_d = tfbp_pkg::PH_START_LF;
        else if (tok_i.is_print) begin
          cnt_d = 13'd1; phase_d = tfbp_pkg::PH_CMD; cl = tfbp_pkg::CL_CMD; ob = c;
        end else fail = 1'b1;
      end
      tfbp_pkg::PH_START_LF: begin
        if (tok_i.is_lf) done = 1'b1; else fail = 1'b1;
      end
      tfbp_pkg::PH_CMD, tfbp_pkg::PH_CMD_LF: begin
        if (tok_i.is_lf) begin
          cnt_d = '0; phase_d = tfbp_pkg::PH_HDR; cl = tfbp_pkg::CL_CMD_END;
        end else if (phase_q == tfbp_pkg::PH_CMD_LF) fail = 1'b1;
        else if (tok_i.is_cr) phase_d = tfbp_pkg::PH_CMD_LF;
        else if (tok_i.is_print) begin
          if (cnt_q < cmd_lim_i) begin
            cnt_d = cnt_q + 13'd1; cl = tfbp_pkg::CL_CMD; ob = c;
          end else begin
            fk_d = tfbp_pkg::ERR_CMD_LONG; fail = 1'b1;
          end
        end else fail = 1'b1;
      end
      tfbp_pkg::PH_HDR, tfbp_pkg::PH_HDR_LF: begin
        if (tok_i.is_lf) begin
          if (lp_q) begin
            if (lbad_q) fail = 1'b1;
            else begin
              rem_d = dlen_q;
              phase_d = (dlen_q != '0) ? tfbp_pkg::PH_BODY_LEN : tfbp_pkg::PH_BODY_FINAL;
            end
          end else phase_d = tfbp_pkg::PH_BODY_NUL;
        end else if (phase_q == tfbp_pkg::PH_HDR_LF || tok_i.is_colon) fail = 1'b1;
        else if (tok_i.is_cr) phase_d = tfbp_pkg::PH_HDR_LF;
        else if (tok_i.is_print) begin
          kmatch_d = c == tfbp_pkg::key_char(4'd0);
          kpos_d = kmatch_d ? 4'd1 : 4'd0;
          cnt_d = 13'd1; phase_d = tfbp_pkg::PH_KEY; cl = tfbp_pkg::CL_KEY; ob = c;
        end else fail = 1'b1;
      end
      tfbp_pkg::PH_KEY: begin
        if (tok_i.is_lf || tok_i.is_cr) fail = 1'b1;
        else if (tok_i.is_colon) begin
          isl_d = kmatch_q && kpos_q == 4'(tfbp_pkg::ClLen);
          cnt_d = '0; dv_d = 1'b0; acc_d = '0; phase_d = tfbp_pkg::PH_VAL;
          cl = tfbp_pkg::CL_KEY_END;
        end else if (tok_i.is_print) begin
          if (cnt_q < key_lim_i) begin
            if (kmatch_q && kpos_q < 4'(tfbp_pkg::ClLen) && c == tfbp_pkg::key_char(kpos_q))
              kpos_d = kpos_q + 4'd1;
            else kmatch_d = 1'b0;
            cnt_d = cnt_q + 13'd1; cl = tfbp_pkg::CL_KEY; ob = c;
          end else begin
            fk_d = tfbp_pkg::ERR_HDR_LARGE; fail = 1'b1;
          end
        end else fail = 1'b1;
      end
      tfbp_pkg::PH_VAL, tfbp_pkg::PH_VAL_LF: begin
        if (tok_i.is_lf) begin
          if (isl_q) begin
            lp_d = 1'b1; lbad_d = !dv_q; dlen_d = acc_q;
          end
          cnt_d = '0; isl_d = 1'b0; dv_d = 1'b0; acc_d = '0;
          phase_d = tfbp_pkg::PH_HDR; cl = tfbp_pkg::CL_VAL_END;
        end else if (phase_q == tfbp_pkg::PH_VAL_LF) fail = 1'b1;
        else if (tok_i.is_cr) phase_d = tfbp_pkg::PH_VAL_LF;
        else if (tok_i.is_print) begin
          if (cnt_q < val_lim_i) begin
            if (!tok_i.is_digit) dv_d = 1'b0;
            else if (cnt_q == '0) begin
              dv_d = 1'b1; acc_d = LW'(tok_i.digit);
            end else if (dv_q) begin
              if (prod[LW+3:LW] != 4'd0) dv_d = 1'b0;
              else acc_d = prod[LW-1:0];
            end
            cnt_d = cnt_q + 13'd1; cl = tfbp_pkg::CL_VAL; ob = c;
          end else begin
            fk_d = tfbp_pkg::ERR_HDR_LARGE; fail = 1'b1;
          end
        end else fail = 1'b1;
      end
      tfbp_pkg::PH_BODY_NUL: begin
        if (tok_i.is_nul) done = 1'b1;
        else begin
          cl = tfbp_pkg::CL_BODY; ob = c;
        end
      end
      tfbp_pkg::PH_BODY_LEN: begin
        cl = tfbp_pkg::CL_BODY; ob = c;
        rem_d = rem_q - LW'(1);
        if (rem_q == LW'(1)) phase_d = tfbp_pkg::PH_BODY_FINAL;
      end
      tfbp_pkg::PH_BODY_FINAL: begin
        if (tok_i.is_nul) done = 1'b1; else fail = 1'b1;
      end
      default: fail = 1'b1;
    endcase
    st = tfbp_pkg::ST_MORE;
    if (fail) begin
      st = tfbp_pkg::ST_FAIL; cl = tfbp_pkg::CL_NONE; ob = 8'h00;
    end else if (done) begin
      st = tfbp_pkg::ST_DONE; cl = tfbp_pkg::CL_NONE; ob = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tfbp_pkg::PH_START; cnt_q <= '0; kpos_q <= '0; kmatch_q <= 1'b1;
      isl_q <= 1'b0; dv_q <= 1'b0; lp_q <= 1'b0; lbad_q <= 1'b0;
      acc_q <= '0; dlen_q <= '0; rem_q <= '0; fk_q <= tfbp_pkg::ERR_BAD;
      ov_q <= 1'b0;
    end else begin
      if (out_valid && out_ready) ov_q <= 1'b0;
      if (step) begin
        ov_q <= 1'b1;
        if (fail || done) begin
          phase_q <= tfbp_pkg::PH_START; cnt_q <= '0; kpos_q <= '0; kmatch_q <= 1'b1;
          isl_q <= 1'b0; dv_q <= 1'b0; lp_q <= 1'b0; lbad_q <= 1'b0;
          acc_q <= '0; dlen_q <= '0; rem_q <= '0; fk_q <= tfbp_pkg::ERR_BAD;
        end else begin
          phase_q <= phase_d; cnt_q <= cnt_d; kpos_q <= kpos_d; kmatch_q <= kmatch_d;
          isl_q <= isl_d; dv_q <= dv_d; lp_q <= lp_d; lbad_q <= lbad_d;
          acc_q <= acc_d; dlen_q <= dlen_d; rem_q <= rem_d; fk_q <= fk_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      st_q <= st;
      ek_q <= fail ? fk_d : tfbp_pkg::ERR_BAD;
      cl_q <= cl;
      ob_q <= ob;
    end
  end

  assign out_valid    = ov_q;
  assign status_o     = st_q;
  assign error_kind_o = ek_q;
  assign byte_class_o = cl_q;
  assign out_byte_o   = ob_q;
endmodule

[hdl/text_frame_byte_parser.sv]
// ----------------------------------------------------------------------------
// text_frame_byte_parser
// Streaming text frame parser: one byte in, one tagged result out.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_byte_i
// out     | output    | out_valid / out_ready| status_o, error_kind_o, byte_class_o, out_byte_o
// cfg     | input     | cfg_we_i             | cfg_idx_i, cfg_data_i
// One byte per cycle sustained while out_ready stays high; results pass input queue, result register.
// The parse state machine step sets the cycle time.
// Reset clears the parser to frame start and limits to 256/256/4096.
// Output stall fills the two-entry queue, then drops in_ready.
`timescale 1ns / 1ps
module text_frame_byte_parser #(
  parameter int unsigned LENGTH_BITS = tfbp_pkg::LengthBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status_o,
  output logic [1:0]  error_kind_o,
  output logic [2:0]  byte_class_o,
  output logic [7:0]  out_byte_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);
  logic [12:0]    cmd_lim_q, key_lim_q, val_lim_q;
  logic           tok_valid, tok_ready;
  tfbp_pkg::tok_t tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_lim_q <= 13'd256;
      key_lim_q <= 13'd256;
      val_lim_q <= 13'd4096;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tfbp_pkg::CFG_CMD) cmd_lim_q <= cfg_data_i;
      if (cfg_idx_i == tfbp_pkg::CFG_KEY) key_lim_q <= cfg_data_i;
      if (cfg_idx_i == tfbp_pkg::CFG_VAL) val_lim_q <= cfg_data_i;
    end
  end

  tfbp_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .in_byte_i,
    .tok_valid_o(tok_valid), .tok_ready_i(tok_ready), .tok_o(tok)
  );

  tfbp_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk_i, .rst_ni, .tok_valid_i(tok_valid), .tok_ready_o(tok_ready), .tok_i(tok),
    .cmd_lim_i(cmd_lim_q), .key_lim_i(key_lim_q), .val_lim_i(val_lim_q),
    .out_valid, .out_ready, .status_o, .error_kind_o, .byte_class_o, .out_byte_o
  );
endmodule

[hdl/tfbp_checker.sv]
// ----------------------------------------------------------------------------
// tfbp_checker
// Port-level checks of the text frame byte parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_frame_byte_parser_macros.svh"
module tfbp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status_o,
  input logic [1:0] error_kind_o,
  input logic [2:0] byte_class_o,
  input logic [7:0] out_byte_o
);
  logic st_more, st_fail, no_data, err_none, end_cls;

  assign st_more  = status_o == tfbp_pkg::ST_MORE;
  assign st_fail  = status_o == tfbp_pkg::ST_FAIL;
  assign no_data  = byte_class_o == tfbp_pkg::CL_NONE && out_byte_o == 8'h00;
  assign err_none = error_kind_o == tfbp_pkg::ERR_BAD;
  assign end_cls  = byte_class_o == tfbp_pkg::CL_CMD_END ||
                    byte_class_o == tfbp_pkg::CL_KEY_END ||
                    byte_class_o == tfbp_pkg::CL_VAL_END;

  `TFBP_ASSERT_IMP(a_fail_no_class, clk_i, rst_ni, out_valid && !st_more, no_data)
  `TFBP_ASSERT_IMP(a_err_only_fail, clk_i, rst_ni, out_valid && !st_fail, err_none)
  `TFBP_ASSERT_IMP(a_no_byte_on_end, clk_i, rst_ni, out_valid && end_cls, out_byte_o == 8'h00)
  `TFBP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_byte_o))
endmodule

bind text_frame_byte_parser tfbp_checker u_checker (
  .clk_i, .rst_ni, .out_valid, .out_ready, .status_o, .error_kind_o, .byte_class_o,
  .out_byte_o
);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_frame_byte_parser: builds well-formed and
// broken frames, predicts each tagged byte and compares it with the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import tfbp_pkg::*;

  typedef struct packed {
    status_e    st;
    err_e       ek;
    class_e     cls;
    logic [7:0] ob;
  } tag_t;

  // frame parser prediction and pending tag queue
  class frame_scoreboard;
    phase_e      phase;
    logic [12:0] cnt;
    logic [12:0] lim_cmd, lim_key, lim_val;
    logic [3:0]  kpos;
    bit          kmatch, is_len, dig_ok, len_seen, len_bad;
    logic [63:0] acc, decl, remain;
    err_e        fkind;
    tag_t        pending[$];
    int          errors;

    function void restart();
      phase = PH_START; cnt = '0; kpos = '0; kmatch = 1; is_len = 0; acc = '0;
      dig_ok = 0; len_seen = 0; len_bad = 0; decl = '0; remain = '0;
      fkind = ERR_BAD;
    endfunction

    function void clear();
      lim_cmd = 13'd256; lim_key = 13'd256; lim_val = 13'd4096; errors = 0;
      restart();
    endfunction

    function void set_limit(logic [1:0] idx, logic [12:0] v);
      if (idx == CFG_CMD) lim_cmd = v;
      else if (idx == CFG_KEY) lim_key = v;
      else if (idx == CFG_VAL) lim_val = v;
    endfunction

    function bit printable(logic [7:0] c);
      return c >= 8'h20 && c <= 8'h7E;
    endfunction

    function void track_key(logic [7:0] c);
      string s;
      s = "content-length";
      if (kmatch && kpos < ClLen && c == s[kpos]) kpos++;
      else kmatch = 0;
    endfunction

    function void take_digit(logic [7:0] c);
      logic [63:0] d;
      if (c < "0" || c > "9") begin
        dig_ok = 0;
        return;
      end
      d = 64'(c - "0");
      if (cnt == 0) begin
        dig_ok = 1; acc = d;
      end else if (dig_ok) begin
        if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) dig_ok = 0;
        else acc = acc * 64'd10 + d;
      end
    endfunction

    function bit open_body();
      if (len_seen) begin
        if (len_bad) return 0;
        remain = decl;
        phase = (remain != 0) ? PH_BODY_LEN : PH_BODY_FINAL;
      end else phase = PH_BODY_NUL;
      return 1;
    endfunction

    function void close_value();
      if (is_len) begin
        len_seen = 1; len_bad = !dig_ok; decl = acc;
      end
      cnt = '0; is_len = 0; dig_ok = 0; acc = '0; phase = PH_HDR;
    endfunction

    function void note_byte(logic [7:0] c);
      tag_t t;
      bit fail, done;
      fail = 0; done = 0;
      t = '{ST_MORE, ERR_BAD, CL_NONE, 8'h00};
      case (phase)
        PH_START:
          if (c == CH_LF) done = 1;
          else if (c == CH_CR) phase = PH_START_LF;
          else if (printable(c)) begin
            cnt = 13'd1; phase = PH_CMD; t.cls = CL_CMD; t.ob = c;
          end else fail = 1;
        PH_START_LF: if (c == CH_LF) done = 1; else fail = 1;
        PH_CMD:
          if (c == CH_LF) begin
            cnt = '0; phase = PH_HDR; t.cls = CL_CMD_END;
          end else if (c == CH_CR) phase = PH_CMD_LF;
          else if (printable(c)) begin
            if (cnt < lim_cmd) begin
              cnt++; t.cls = CL_CMD; t.ob = c;
            end else begin
              fkind = ERR_CMD_LONG; fail = 1;
            end
          end else fail = 1;
        PH_CMD_LF:
          if (c == CH_LF) begin
            cnt = '0; phase = PH_HDR; t.cls = CL_CMD_END;
          end else fail = 1;
        PH_HDR:
          if (c == CH_LF) fail = !open_body();
          else if (c == CH_COLON) fail = 1;
          else if (c == CH_CR) phase = PH_HDR_LF;
          else if (printable(c)) begin
            kpos = '0; kmatch = 1; track_key(c); cnt = 13'd1; phase = PH_KEY;
            t.cls = CL_KEY; t.ob = c;
          end else fail = 1;
        PH_HDR_LF: if (c == CH_LF) fail = !open_body(); else fail = 1;
        PH_KEY:
          if (c == CH_LF || c == CH_CR) fail = 1;
          else if (c == CH_COLON) begin
            is_len = kmatch && kpos == ClLen; cnt = '0; dig_ok = 0; acc = '0;
            phase = PH_VAL; t.cls = CL_KEY_END;
          end else if (printable(c)) begin
            if (cnt < lim_key) begin
              track_key(c); cnt++; t.cls = CL_KEY; t.ob = c;
            end else begin
              fkind = ERR_HDR_LARGE; fail = 1;
            end
          end else fail = 1;
        PH_VAL:
          if (c == CH_LF) begin
            close_value(); t.cls = CL_VAL_END;
          end else if (c == CH_CR) phase = PH_VAL_LF;
          else if (printable(c)) begin
            if (cnt < lim_val) begin
              take_digit(c); cnt++; t.cls = CL_VAL; t.ob = c;
            end else begin
              fkind = ERR_HDR_LARGE; fail = 1;
            end
          end else fail = 1;
        PH_VAL_LF:
          if (c == CH_LF) begin
            close_value(); t.cls = CL_VAL_END;
          end else fail = 1;
        PH_BODY_NUL:
          if (c == 8'h00) done = 1;
          else begin
            t.cls = CL_BODY; t.ob = c;
          end
        PH_BODY_LEN: begin
          t.cls = CL_BODY; t.ob = c;
          if (remain != 0) remain--;
          if (remain == 0) phase = PH_BODY_FINAL;
        end
        PH_BODY_FINAL: if (c == 8'h00) done = 1; else fail = 1;
        default: fail = 1;
      endcase
      if (fail) begin
        t = '{ST_FAIL, fkind, CL_NONE, 8'h00};
        restart();
      end else if (done) begin
        t = '{ST_DONE, ERR_BAD, CL_NONE, 8'h00};
        restart();
      end
      pending = {pending, t};
    endfunction

    function void check_tag(tag_t got);
      tag_t exp;
      if (pending.size() == 0) begin
        $display("%0t unexpected transaction: actual %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.st != exp.st) begin
        $display("%0t status: expected %0d actual %0d", $time, exp.st, got.st);
        errors++;
      end
      if (got.ek != exp.ek) begin
        $display("%0t error_kind: expected %0d actual %0d", $time, exp.ek, got.ek);
        errors++;
      end
      if (got.cls != exp.cls) begin
        $display("%0t byte_class: expected %0d actual %0d", $time, exp.cls, got.cls);
        errors++;
      end
      if (got.ob != exp.ob) begin
        $display("%0t out_byte: expected %h actual %h", $time, exp.ob, got.ob);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  in_byte_i = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  status_o, error_kind_o;
  logic [2:0]  byte_class_o;
  logic [7:0]  out_byte_o;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = 0;
  logic [12:0] cfg_data_i = 0;

  int send_idle_pct, recv_idle_pct, stall_cycles, sent;
  frame_scoreboard sb;
  byte unsigned stream[$];

  text_frame_byte_parser dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_byte(in_byte_i);
      if (out_valid && out_ready)
        sb.check_tag('{status_e'(status_o), err_e'(error_kind_o),
                       class_e'(byte_class_o), out_byte_o});
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 2000) begin
        $display("text_frame_byte_parser: mismatch");
        $finish;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid <= 1;
    in_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic flush();
    byte unsigned b;
    while (stream.size() != 0) begin
      b = stream.pop_front();
      send_byte(b);
    end
    in_valid <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [1:0] idx, input logic [12:0] v);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_limit(idx, v);
  endtask

  task automatic put_byte(input byte unsigned b);
    stream = {stream, b};
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic push_eol();
    if ($urandom_range(1)) put_byte(CH_CR);
    put_byte(CH_LF);
  endtask

  task automatic push_word(input int n, input bit digits);
    byte unsigned c;
    for (int i = 0; i < n; i++) begin
      c = digits ? 8'("0" + $urandom_range(9)) : 8'($urandom_range(8'h7E, 8'h20));
      if (c == CH_COLON) c = "x";
      put_byte(c);
    end
  endtask

  // one random frame: mostly well formed, sometimes corrupted
  task automatic push_frame();
    int nh, blen;
    bit with_len;
    if ($urandom_range(9) == 0) begin
      push_eol();
      return;
    end
    push_word($urandom_range(8, 1), 0);
    push_eol();
    nh = $urandom_range(3, 0);
    with_len = $urandom_range(1);
    blen = $urandom_range(6, 0);
    for (int h = 0; h < nh; h++) begin
      push_word($urandom_range(6, 1), 0); put_byte(CH_COLON);
      push_word($urandom_range(6, 0), 0); push_eol();
    end
    if (with_len) begin
      push_str("content-length:");
      case ($urandom_range(7))
        0: push_str("");
        1: push_str("99999999999999999999999");
        2: push_str("1x");
        default: push_str($sformatf("%0d", blen));
      endcase
      push_eol();
    end
    push_eol();
    for (int i = 0; i < blen; i++)
      put_byte(with_len ? 8'($urandom_range(255)) : 8'($urandom_range(255, 1)));
    put_byte(8'h00);
    if ($urandom_range(7) == 0)
      stream[$urandom_range(stream.size() - 1)] = 8'($urandom_range(255));
    if ($urandom_range(15) == 0) push_word($urandom_range(4, 1), 0);
  endtask

  task automatic random_phase(input int n);
    int goal;
    goal = sent + n;
    while (sent < goal) begin
      push_frame();
      flush();
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    stall_cycles = 0;
    sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: heartbeats, full frame, length handling, bad bytes, limits
    push_str("\n\r\nSEND\r\ncontent-length:3\nk:\r\n\n");
    put_byte(8'h00); put_byte(8'hFF); put_byte(8'h00);
    push_str("A\ncontent-length:0\n\n"); put_byte(8'h00);
    push_str("B\n:\rX\n\x80~ \n");
    flush();
    drain();
    write_limit(CFG_CMD, 13'd0);
    write_limit(CFG_KEY, 13'd1);
    write_limit(CFG_VAL, 13'd1);
    push_str("AB\nA\nkk\nA\nk:12\nA\nk:1\n\n"); put_byte(8'h00);
    push_str("A\ncontent-length:\n\nA\ncontent-length:18446744073709551616\n\n");
    flush();
    drain();
    write_limit(CFG_CMD, 13'h1FFF);
    write_limit(CFG_KEY, 13'h1FFF);
    write_limit(CFG_VAL, 13'h1FFF);

    send_idle_pct = 17; recv_idle_pct = 67;
    random_phase(350);
    drain();
    write_limit(CFG_CMD, 13'd4);
    write_limit(CFG_KEY, 13'd3);
    write_limit(CFG_VAL, 13'd2);
    send_idle_pct = 67; recv_idle_pct = 17;
    random_phase(350);
    drain();
    write_limit(CFG_CMD, 13'd4096);
    write_limit(CFG_KEY, 13'd256);
    write_limit(CFG_VAL, 13'd4096);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(350);
    drain();
    repeat (10) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("text_frame_byte_parser: match");
    else
      $display("text_frame_byte_parser: mismatch");
    $finish;
  end
endmodule

[sim.f]
+incdir+hdl
hdl/tfbp_pkg.sv
hdl/tfbp_front.sv
hdl/tfbp_back.sv
hdl/text_frame_byte_parser.sv
hdl/tfbp_checker.sv
bench/tb.sv
